// ===== hw/rtl/mftr_pkg.sv =====
// ----------------------------------------------------------------------------
// mftr_pkg
// Shared constants, command codes and the 6x8 font table of the monochrome
// page framebuffer text renderer.
// ----------------------------------------------------------------------------
package mftr_pkg;

    // visible display size
    localparam int DISPLAY_WIDTH = 128;
    localparam int DISPLAY_PAGES = 8;

    // physical store geometry, pages of column bytes
    localparam int STORE_COLS  = 128;
    localparam int STORE_PAGES = 8;
    localparam int STORE_DEPTH = STORE_COLS * STORE_PAGES;
    localparam int COL_W       = $clog2(STORE_COLS);
    localparam int PAGE_W      = $clog2(STORE_PAGES);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // font geometry and code range
    localparam int GLYPH_W     = 6;
    localparam int GLYPH_H     = 8;
    localparam int FIRST_CODE  = 32;
    localparam int LAST_CODE   = 126;
    localparam int GLYPH_COUNT = LAST_CODE - FIRST_CODE + 1;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam int GLYPH_COL_W = $clog2(GLYPH_W);

    // command codes
    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_FILL   = 3'd1,
        ACT_PIXEL  = 3'd2,
        ACT_GLYPH  = 3'd3,
        ACT_CURSOR = 3'd4,
        ACT_CHAR   = 3'd5,
        ACT_READ   = 3'd6
    } t_action;

    // font table: [glyph][column], bit 0 is the top row
    localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_W] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00,8'h00},
        '{8'h00,8'h07,8'h00,8'h07,8'h00,8'h00}, '{8'h14,8'h7F,8'h14,8'h7F,8'h14,8'h00},
        '{8'h24,8'h2A,8'h7F,8'h2A,8'h12,8'h00}, '{8'h23,8'h13,8'h08,8'h64,8'h62,8'h00},
        '{8'h36,8'h49,8'h55,8'h22,8'h50,8'h00}, '{8'h00,8'h05,8'h03,8'h00,8'h00,8'h00},
        '{8'h00,8'h1C,8'h22,8'h41,8'h00,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00,8'h00},
        '{8'h08,8'h2A,8'h1C,8'h2A,8'h08,8'h00}, '{8'h08,8'h08,8'h3E,8'h08,8'h08,8'h00},
        '{8'h00,8'h50,8'h30,8'h00,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08,8'h00},
        '{8'h00,8'h60,8'h60,8'h00,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02,8'h00},
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E,8'h00}, '{8'h00,8'h42,8'h7F,8'h40,8'h00,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46,8'h00}, '{8'h21,8'h41,8'h45,8'h4B,8'h31,8'h00},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10,8'h00}, '{8'h27,8'h45,8'h45,8'h45,8'h39,8'h00},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h30,8'h00}, '{8'h01,8'h71,8'h09,8'h05,8'h03,8'h00},
        '{8'h36,8'h49,8'h49,8'h49,8'h36,8'h00}, '{8'h06,8'h49,8'h49,8'h29,8'h1E,8'h00},
        '{8'h00,8'h36,8'h36,8'h00,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00,8'h00},
        '{8'h00,8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14,8'h00},
        '{8'h41,8'h22,8'h14,8'h08,8'h00,8'h00}, '{8'h02,8'h01,8'h51,8'h09,8'h06,8'h00},
        '{8'h32,8'h49,8'h79,8'h41,8'h3E,8'h00}, '{8'h7E,8'h11,8'h11,8'h11,8'h7E,8'h00},
        '{8'h7F,8'h49,8'h49,8'h49,8'h36,8'h00}, '{8'h3E,8'h41,8'h41,8'h41,8'h22,8'h00},
        '{8'h7F,8'h41,8'h41,8'h22,8'h1C,8'h00}, '{8'h7F,8'h49,8'h49,8'h49,8'h41,8'h00},
        '{8'h7F,8'h09,8'h09,8'h01,8'h01,8'h00}, '{8'h3E,8'h41,8'h41,8'h51,8'h32,8'h00},
        '{8'h7F,8'h08,8'h08,8'h08,8'h7F,8'h00}, '{8'h00,8'h41,8'h7F,8'h41,8'h00,8'h00},
        '{8'h20,8'h40,8'h41,8'h3F,8'h01,8'h00}, '{8'h7F,8'h08,8'h14,8'h22,8'h41,8'h00},
        '{8'h7F,8'h40,8'h40,8'h40,8'h40,8'h00}, '{8'h7F,8'h02,8'h04,8'h02,8'h7F,8'h00},
        '{8'h7F,8'h04,8'h08,8'h10,8'h7F,8'h00}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E,8'h00},
        '{8'h7F,8'h09,8'h09,8'h09,8'h06,8'h00}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E,8'h00},
        '{8'h7F,8'h09,8'h19,8'h29,8'h46,8'h00}, '{8'h46,8'h49,8'h49,8'h49,8'h31,8'h00},
        '{8'h01,8'h01,8'h7F,8'h01,8'h01,8'h00}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F,8'h00},
        '{8'h1F,8'h20,8'h40,8'h20,8'h1F,8'h00}, '{8'h7F,8'h20,8'h18,8'h20,8'h7F,8'h00},
        '{8'h63,8'h14,8'h08,8'h14,8'h63,8'h00}, '{8'h03,8'h04,8'h78,8'h04,8'h03,8'h00},
        '{8'h61,8'h51,8'h49,8'h45,8'h43,8'h00}, '{8'h00,8'h00,8'h7F,8'h41,8'h41,8'h00},
        '{8'h02,8'h04,8'h08,8'h10,8'h20,8'h00}, '{8'h41,8'h41,8'h7F,8'h00,8'h00,8'h00},
        '{8'h04,8'h02,8'h01,8'h02,8'h04,8'h00}, '{8'h40,8'h40,8'h40,8'h40,8'h40,8'h00},
        '{8'h00,8'h01,8'h02,8'h04,8'h00,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78,8'h00},
        '{8'h7F,8'h48,8'h44,8'h44,8'h38,8'h00}, '{8'h38,8'h44,8'h44,8'h44,8'h20,8'h00},
        '{8'h38,8'h44,8'h44,8'h48,8'h7F,8'h00}, '{8'h38,8'h54,8'h54,8'h54,8'h18,8'h00},
        '{8'h08,8'h7E,8'h09,8'h01,8'h02,8'h00}, '{8'h08,8'h14,8'h54,8'h54,8'h3C,8'h00},
        '{8'h7F,8'h08,8'h04,8'h04,8'h78,8'h00}, '{8'h00,8'h44,8'h7D,8'h40,8'h00,8'h00},
        '{8'h20,8'h40,8'h44,8'h3D,8'h00,8'h00}, '{8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h41,8'h7F,8'h40,8'h00,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78,8'h00},
        '{8'h7C,8'h08,8'h04,8'h04,8'h78,8'h00}, '{8'h38,8'h44,8'h44,8'h44,8'h38,8'h00},
        '{8'h7C,8'h14,8'h14,8'h14,8'h08,8'h00}, '{8'h08,8'h14,8'h14,8'h18,8'h7C,8'h00},
        '{8'h7C,8'h08,8'h04,8'h04,8'h08,8'h00}, '{8'h48,8'h54,8'h54,8'h54,8'h20,8'h00},
        '{8'h04,8'h3F,8'h44,8'h40,8'h20,8'h00}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C,8'h00},
        '{8'h1C,8'h20,8'h40,8'h20,8'h1C,8'h00}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C,8'h00},
        '{8'h44,8'h28,8'h10,8'h28,8'h44,8'h00}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C,8'h00},
        '{8'h44,8'h64,8'h54,8'h4C,8'h44,8'h00}, '{8'h00,8'h08,8'h36,8'h41,8'h00,8'h00},
        '{8'h00,8'h00,8'h7F,8'h00,8'h00,8'h00}, '{8'h00,8'h41,8'h36,8'h08,8'h00,8'h00},
        '{8'h08,8'h08,8'h2A,8'h1C,8'h08,8'h00}
    };

endpackage

// ===== hw/rtl/mftr_ram.sv =====
// ----------------------------------------------------------------------------
// mftr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mftr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/mono_framebuffer_text_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_text_renderer_unit
// 128x64 monochrome page framebuffer with a 6x8 text renderer and readback.
// ----------------------------------------------------------------------------
// One command is taken at a time and answers with exactly one result. The
// framebuffer lives in a 1024x8 RAM with registered read data; pixel and
// glyph drawing is read-modify-write through it, while clear and fill write
// whole bytes, one RAM byte per cycle. A glyph or cursor character makes
// twelve byte accesses, two pages by six columns, pipelined one per cycle;
// a dropped cursor character writes nothing. After reset a clearing pass
// over all 1024 bytes runs before the first command is taken. A new command
// is taken while a previous result still waits on the output; a finished
// result then waits until the output register is free.
module mono_framebuffer_text_renderer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_action,
    input  logic [7:0] i_x_pos,
    input  logic [7:0] i_y_pos,
    input  logic       i_colour,
    input  logic [7:0] i_character,
    input  logic       i_invert,
    input  logic [2:0] i_read_page,
    input  logic [6:0] i_read_column,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_byte,
    output logic       o_text_dropped,
    output logic [7:0] o_cursor_column,
    output logic [7:0] o_cursor_row
);

    localparam int AW = mftr_pkg::ADDR_W;
    localparam int GW = mftr_pkg::GLYPH_IDX_W;
    localparam int CW = mftr_pkg::GLYPH_COL_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SWEEP = 6'b000010,
        S_GLYPH = 6'b000100,
        S_DRAIN = 6'b001000,
        S_RDATA = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [3:0]      r_step, n_step;
    logic [AW-1:0]   r_sweep_addr, n_sweep_addr;
    logic            r_sweep_cmd, n_sweep_cmd;
    logic [7:0]      r_fill, n_fill;
    logic [7:0]      r_gx, n_gx;
    logic [7:0]      r_gy, n_gy;
    logic [GW-1:0]   r_gidx, n_gidx;
    logic            r_inv, n_inv;
    logic [7:0]      r_text_x, n_text_x;
    logic [7:0]      r_text_y, n_text_y;
    logic            r_rd_ok, n_rd_ok;
    logic [7:0]      r_pend_byte, n_pend_byte;
    logic            r_drop, n_drop;
    logic            r_wv, n_wv;
    logic [AW-1:0]   r_waddr, n_waddr;
    logic [7:0]      r_wm, n_wm;
    logic [7:0]      r_wd, n_wd;
    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_o_byte, n_o_byte;
    logic            r_o_drop, n_o_drop;
    logic [7:0]      r_o_col, n_o_col;
    logic [7:0]      r_o_row, n_o_row;

    logic            c_accept;
    logic [AW-1:0]   c_raddr;
    logic [7:0]      ram_rdata;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;

    // glyph step signals
    logic [CW-1:0]   g_i;
    logic            g_k;
    logic [7:0]      g_px;
    logic [4:0]      g_page;
    logic [2:0]      g_shift;
    logic [7:0]      g_bits;
    logic [7:0]      g_mask;
    logic [7:0]      g_data;
    logic            g_ok;
    logic            g_last;

    // cursor character signals
    logic            c_wrap;
    logic [7:0]      c_tx;
    logic [7:0]      c_ty;
    logic            c_drop;
    logic [GW-1:0]   c_gidx;

    assign o_in_ready = (r_state == S_IDLE);
    assign c_accept   = i_in_valid && (r_state == S_IDLE);

    // byte access of the current glyph step: column i, page slot k
    always_comb begin
        g_i     = r_step[CW:1];
        g_k     = r_step[0];
        g_px    = r_gx + 8'(g_i);
        g_page  = r_gy[7:3] + 5'(g_k);
        g_shift = r_gy[2:0];
        g_bits  = mftr_pkg::GLYPH_ROM[r_gidx][g_i];
        if (!g_k) begin
            g_mask = 8'hFF << g_shift;
            g_data = g_bits << g_shift;
        end else begin
            g_mask = ~(8'hFF << g_shift);
            g_data = g_bits >> (4'd8 - {1'b0, g_shift});
        end
        g_ok   = (int'(g_px) < mftr_pkg::DISPLAY_WIDTH) &&
                 (int'(g_page) < mftr_pkg::DISPLAY_PAGES) &&
                 (!g_k || (g_shift != 3'd0));
        g_last = (r_step == 4'(2 * mftr_pkg::GLYPH_W - 1));
    end

    // cursor wrap and bottom test
    always_comb begin
        c_wrap = ({1'b0, r_text_x} + 9'(mftr_pkg::GLYPH_W)) >
                 9'(mftr_pkg::DISPLAY_WIDTH);
        c_tx   = c_wrap ? 8'd0 : r_text_x;
        c_ty   = c_wrap ? (r_text_y + 8'(mftr_pkg::GLYPH_H)) : r_text_y;
        c_drop = ({1'b0, c_ty} + 9'(mftr_pkg::GLYPH_H)) >
                 9'(8 * mftr_pkg::DISPLAY_PAGES);
        if ((i_character < 8'(mftr_pkg::FIRST_CODE)) ||
            (i_character > 8'(mftr_pkg::LAST_CODE))) begin
            c_gidx = '0;
        end else begin
            c_gidx = GW'(i_character - 8'(mftr_pkg::FIRST_CODE));
        end
    end

    // read address: glyph steps, else the accepted command
    always_comb begin
        if (r_state == S_GLYPH) begin
            c_raddr = {g_page[mftr_pkg::PAGE_W-1:0], g_px[mftr_pkg::COL_W-1:0]};
        end else if (i_action == mftr_pkg::ACT_PIXEL) begin
            c_raddr = {i_y_pos[mftr_pkg::PAGE_W+2:3], i_x_pos[mftr_pkg::COL_W-1:0]};
        end else begin
            c_raddr = {i_read_page, i_read_column};
        end
    end

    // write port: sweep or merge of the byte read in the cycle before
    always_comb begin
        ram_we    = (r_state == S_SWEEP) || r_wv;
        ram_waddr = (r_state == S_SWEEP) ? r_sweep_addr : r_waddr;
        ram_wdata = (r_state == S_SWEEP) ? r_fill
                                         : ((ram_rdata & ~r_wm) | (r_wd & r_wm));
    end

    mftr_ram #(
        .WIDTH (8),
        .DEPTH (mftr_pkg::STORE_DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (c_raddr),
        .o_rdata (ram_rdata)
    );

    // command sequencer
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_sweep_addr = r_sweep_addr;
        n_sweep_cmd  = r_sweep_cmd;
        n_fill       = r_fill;
        n_gx         = r_gx;
        n_gy         = r_gy;
        n_gidx       = r_gidx;
        n_inv        = r_inv;
        n_text_x     = r_text_x;
        n_text_y     = r_text_y;
        n_rd_ok      = r_rd_ok;
        n_pend_byte  = r_pend_byte;
        n_drop       = r_drop;
        n_wv         = 1'b0;
        n_waddr      = r_waddr;
        n_wm         = r_wm;
        n_wd         = r_wd;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_o_byte     = r_o_byte;
        n_o_drop     = r_o_drop;
        n_o_col      = r_o_col;
        n_o_row      = r_o_row;

        unique case (r_state)
            S_IDLE: begin
                if (c_accept) begin
                    n_pend_byte = 8'd0;
                    n_drop      = 1'b0;
                    n_inv       = i_invert;
                    unique case (mftr_pkg::t_action'(i_action))
                        mftr_pkg::ACT_CLEAR, mftr_pkg::ACT_FILL: begin
                            n_fill       = (i_action == mftr_pkg::ACT_FILL) ?
                                           {8{i_colour}} : 8'd0;
                            n_sweep_addr = '0;
                            n_sweep_cmd  = 1'b1;
                            n_state      = S_SWEEP;
                        end
                        mftr_pkg::ACT_PIXEL: begin
                            n_wv    = (int'(i_x_pos) < mftr_pkg::DISPLAY_WIDTH) &&
                                      (int'(i_y_pos) < 8 * mftr_pkg::DISPLAY_PAGES);
                            n_waddr = c_raddr;
                            n_wm    = 8'd1 << i_y_pos[2:0];
                            n_wd    = {8{i_colour}};
                            n_state = S_DRAIN;
                        end
                        mftr_pkg::ACT_GLYPH: begin
                            n_gx    = i_x_pos;
                            n_gy    = i_y_pos;
                            n_gidx  = c_gidx;
                            n_step  = 4'd0;
                            n_state = S_GLYPH;
                        end
                        mftr_pkg::ACT_CURSOR: begin
                            n_text_x = i_x_pos;
                            n_text_y = i_y_pos;
                            n_state  = S_DONE;
                        end
                        mftr_pkg::ACT_CHAR: begin
                            n_text_y = c_ty;
                            if (c_drop) begin
                                n_text_x = c_tx;
                                n_drop   = 1'b1;
                                n_state  = S_DONE;
                            end else begin
                                n_text_x = c_tx + 8'(mftr_pkg::GLYPH_W);
                                n_gx     = c_tx;
                                n_gy     = c_ty;
                                n_gidx   = c_gidx;
                                n_step   = 4'd0;
                                n_state  = S_GLYPH;
                            end
                        end
                        default: begin
                            // read, and the unused code that acts as a read
                            n_rd_ok = (int'(i_read_page) < mftr_pkg::DISPLAY_PAGES) &&
                                      (int'(i_read_column) < mftr_pkg::DISPLAY_WIDTH);
                            n_state = S_RDATA;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                n_sweep_addr = r_sweep_addr + AW'(1);
                if (r_sweep_addr == AW'(mftr_pkg::STORE_DEPTH - 1)) begin
                    n_sweep_cmd = 1'b0;
                    n_state     = r_sweep_cmd ? S_DONE : S_IDLE;
                end
            end
            S_GLYPH: begin
                // issue one read per cycle, merge lands in the next cycle
                n_wv    = g_ok;
                n_waddr = c_raddr;
                n_wm    = r_inv ? g_mask : (g_data & g_mask);
                n_wd    = r_inv ? ~g_data : 8'hFF;
                n_step  = r_step + 4'd1;
                if (g_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_RDATA: begin
                n_pend_byte = r_rd_ok ? ram_rdata : 8'd0;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_byte    = r_pend_byte;
                    n_o_drop    = r_drop;
                    n_o_col     = r_text_x;
                    n_o_row     = r_text_y;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_step       <= 4'd0;
            r_sweep_addr <= '0;
            r_sweep_cmd  <= 1'b0;
            r_fill       <= 8'd0;
            r_text_x     <= 8'd0;
            r_text_y     <= 8'd0;
            r_wv         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_cmd  <= n_sweep_cmd;
            r_fill       <= n_fill;
            r_text_x     <= n_text_x;
            r_text_y     <= n_text_y;
            r_wv         <= n_wv;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_gx        <= n_gx;
        r_gy        <= n_gy;
        r_gidx      <= n_gidx;
        r_inv       <= n_inv;
        r_rd_ok     <= n_rd_ok;
        r_pend_byte <= n_pend_byte;
        r_drop      <= n_drop;
        r_waddr     <= n_waddr;
        r_wm        <= n_wm;
        r_wd        <= n_wd;
        r_o_byte    <= n_o_byte;
        r_o_drop    <= n_o_drop;
        r_o_col     <= n_o_col;
        r_o_row     <= n_o_row;
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_byte     = r_o_byte;
    assign o_text_dropped  = r_o_drop;
    assign o_cursor_column = r_o_col;
    assign o_cursor_row    = r_o_row;

endmodule

// ===== hw/rtl/mftr_checker.sv =====
// ----------------------------------------------------------------------------
// mftr_checker
// Port-level assertions for the framebuffer text renderer, bound to the top.
// ----------------------------------------------------------------------------
module mftr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_read_byte,
    input logic       o_text_dropped,
    input logic [7:0] o_cursor_column,
    input logic [7:0] o_cursor_row
);

    // one command at a time: no input transfer right after one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after an input transfer");

    // a pending result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_read_byte) &&
        $stable(o_text_dropped) && $stable(o_cursor_column) && $stable(o_cursor_row)))
        else $error("pending result changed before transfer");

    // a dropped character is never a read
    a_drop_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_text_dropped) |-> (o_read_byte == 8'd0))
        else $error("dropped character with nonzero read byte");

    // a dropped character means the cursor row is past the bottom
    a_drop_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_text_dropped) |->
        (int'(o_cursor_row) + mftr_pkg::GLYPH_H > 8 * mftr_pkg::DISPLAY_PAGES))
        else $error("dropped character with cursor row on screen");

    // reset leaves no result and no input ready
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_ready))
        else $error("result or ready after reset");

endmodule

bind mono_framebuffer_text_renderer_unit mftr_checker u_mftr_checker (.*);
